FILE: hdl/mrbm_pkg.sv
// Shared types and constants for the maximal-rectangle block.
// No dependencies; every other file in hdl/ uses this package.
`default_nettype none
package mrbm_pkg;

  localparam int AREA_W  = 13;
  localparam int NCOLS_W = 7;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [AREA_W-1:0]  AREA_CAP    = 13'h1FFF;
  localparam logic [NCOLS_W-1:0] NCOLS_RESET = 7'd64;

  // word index of the configuration registers (byte address / 4)
  localparam logic [CFG_AW-3:0] REG_NUM_COLS = 1'b0;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;   // latch the incoming cell
    logic hgt;      // update the column height
    logic pop;      // pop the stack top and offer its area
    logic flush_w;  // width of a pop runs through the current column
    logic push;     // push the current height and start column
    logic col_adv;  // move to the next column
    logic col_zero; // row done, back to column zero
    logic emit;     // load the result and clear the matrix state
  } mrbm_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic top_ge;      // stack not empty and top height >= current height
    logic stack_empty;
    logic row_end;
    logic last;
    logic out_free;
  } mrbm_sts_t;

endpackage
`default_nettype wire

FILE: hdl/mrbm_if.sv
// Valid/ready stream interfaces for the cell input and the area result.
// Depends on mrbm_pkg for the result width.
`default_nettype none
interface mrbm_in_if;
  logic valid;
  logic ready;
  logic cell_bit;
  logic last_cell;

  modport source (output valid, output cell_bit, output last_cell, input ready);
  modport sink (input valid, input cell_bit, input last_cell, output ready);
endinterface

interface mrbm_out_if;
  logic                        valid;
  logic                        ready;
  logic [mrbm_pkg::AREA_W-1:0] rect_area;

  modport source (output valid, output rect_area, input ready);
  modport sink (input valid, input rect_area, output ready);
endinterface
`default_nettype wire

FILE: hdl/mrbm_ctrl.sv
// Sequencer for the maximal-rectangle block: one cell at a time through
// height update, stack pops, push and the row-end flush. Uses mrbm_pkg.
`default_nettype none
module mrbm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrbm_pkg::mrbm_sts_t sts,
  output mrbm_pkg::mrbm_cmd_t cmd
);
  import mrbm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HGT   = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_HGT;
        end
      end
      S_HGT: begin
        cmd.hgt   = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.top_ge) begin
          cmd.pop = 1'b1;
        end else begin
          cmd.push = 1'b1;
          if (sts.row_end) begin
            state_nxt = S_FLUSH;
          end else begin
            cmd.col_adv = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (!sts.stack_empty) begin
          cmd.pop     = 1'b1;
          cmd.flush_w = 1'b1;
        end else if (sts.last) begin
          // the wait state lets the last product reach the running best
          state_nxt = S_WAIT;
        end else begin
          cmd.col_zero = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_WAIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mrbm_dp.sv
// Datapath: column-height memory, height/start stack memory, area
// multiplier, running best and the result register. Uses mrbm_pkg.
`default_nettype none
module mrbm_dp #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mrbm_pkg::mrbm_cmd_t           cmd,
  output mrbm_pkg::mrbm_sts_t           sts,
  input  logic                          in_cell,
  input  logic                          in_last,
  input  logic [mrbm_pkg::NCOLS_W-1:0]  num_cols,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [mrbm_pkg::AREA_W-1:0]   out_area
);
  import mrbm_pkg::*;

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DW = $clog2(MAX_COLS + 1);
  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int PW = HW + DW;
  localparam int NW = (DW > NCOLS_W) ? DW : NCOLS_W;
  localparam int XW = (PW > AREA_W) ? PW : AREA_W;
  localparam int SW = HW + CW;

  logic              cell_r;
  logic              last_r;
  logic [CW-1:0]     col_r;
  logic [HW-1:0]     h_r;
  logic [CW-1:0]     start_r;
  logic [DW-1:0]     depth_r;
  logic [DW-1:0]     depth_nxt;
  logic [PW-1:0]     prod_r;
  logic              pv_r;
  logic [AREA_W-1:0] best_r;
  logic              out_valid_r;
  logic [AREA_W-1:0] out_area_r;

  // column heights; entries read as zero until written since the last clear
  logic [HW-1:0]       hmem [MAX_COLS];
  logic [HW-1:0]       hrd_r;
  logic [MAX_COLS-1:0] hvld_r;
  logic [HW-1:0]       h_old;
  logic [HW-1:0]       h_new;

  // stack of {height, start column}
  logic [SW-1:0] smem [MAX_COLS];
  logic [SW-1:0] srd_r;
  logic [SW-1:0] swd_r;
  logic          sfwd_r;
  logic [SW-1:0] s_wd;
  logic [SW-1:0] s_top;
  logic [HW-1:0] top_h;
  logic [CW-1:0] top_s;
  logic [CW-1:0] s_ra;
  logic [CW-1:0] s_wa;
  logic          s_we;

  logic [NW-1:0]     ncols_ext;
  logic [NW-1:0]     n_eff;
  logic [DW-1:0]     pop_w;
  logic [XW-1:0]     prod_x;
  logic [AREA_W-1:0] area;

  // column count: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    ncols_ext = NW'(num_cols);
    if (ncols_ext == '0) begin
      n_eff = NW'(1);
    end else if (ncols_ext > NW'(MAX_COLS)) begin
      n_eff = NW'(MAX_COLS);
    end else begin
      n_eff = ncols_ext;
    end
  end

  always_comb begin
    h_old = hvld_r[col_r] ? hrd_r : '0;
    if (!cell_r) begin
      h_new = '0;
    end else if (h_old != HW'(MAX_ROWS)) begin
      h_new = h_old + HW'(1);
    end else begin
      h_new = h_old;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hgt) begin
      hmem[col_r] <= h_new;
    end
    hrd_r <= hmem[col_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      hvld_r <= '0;
    end else if (cmd.hgt) begin
      hvld_r[col_r] <= 1'b1;
    end
  end

  // stack: read address follows the next top; forward a push to the same slot
  assign s_we  = cmd.push && (depth_r != DW'(MAX_COLS));
  assign s_wd  = {h_r, start_r};
  assign s_wa  = CW'(depth_r);
  assign s_top = sfwd_r ? swd_r : srd_r;
  assign top_h = s_top[SW-1:CW];
  assign top_s = s_top[CW-1:0];

  always_comb begin
    if (cmd.emit) begin
      depth_nxt = '0;
    end else if (cmd.pop) begin
      depth_nxt = depth_r - DW'(1);
    end else if (s_we) begin
      depth_nxt = depth_r + DW'(1);
    end else begin
      depth_nxt = depth_r;
    end
  end

  assign s_ra = CW'(depth_nxt - DW'(1));

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_wa] <= s_wd;
    end
    srd_r  <= smem[s_ra];
    sfwd_r <= s_we && (s_wa == s_ra);
    swd_r  <= s_wd;
  end

  assign pop_w = cmd.flush_w ? (DW'(col_r) + DW'(1) - DW'(top_s))
                             : (DW'(col_r) - DW'(top_s));

  always_ff @(posedge clk) begin
    prod_r <= PW'(top_h) * PW'(pop_w);
  end

  always_comb begin
    prod_x = XW'(prod_r);
    area   = (prod_x > XW'(AREA_CAP)) ? AREA_CAP : AREA_W'(prod_x);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cell_r <= in_cell;
      last_r <= in_last;
    end
    if (cmd.hgt) begin
      h_r     <= h_new;
      start_r <= col_r;
    end else if (cmd.pop) begin
      start_r <= top_s;
    end
    if (cmd.emit) begin
      out_area_r <= best_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      col_r       <= '0;
      pv_r        <= 1'b0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      pv_r    <= cmd.pop;
      if (cmd.emit || cmd.col_zero) begin
        col_r <= '0;
      end else if (cmd.col_adv) begin
        col_r <= col_r + CW'(1);
      end
      if (cmd.emit) begin
        best_r <= '0;
      end else if (pv_r && (area > best_r)) begin
        best_r <= area;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.top_ge      = (depth_r != '0) && (top_h >= h_r);
  assign sts.stack_empty = (depth_r == '0);
  assign sts.row_end     = ((NW'(col_r) + NW'(1)) >= n_eff) || last_r;
  assign sts.last        = last_r;
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_area  = out_area_r;

endmodule
`default_nettype wire

FILE: hdl/maximal_rectangle_binary_matrix_top.sv
// Largest all-ones rectangle of a binary matrix streamed in row-major order.
//
// in_ch carries one cell per transfer (cell_bit, last_cell). num_cols, at
// byte address 0 of the cfg port, sets the cells per row (reset 64); write
// it only while the block is idle. After the transfer of the cell flagged
// last_cell, out_ch presents rect_area, the area of the largest all-ones
// rectangle, and the block returns to its cleared state for the next matrix.
//
// One cell at a time passes through a shared stack engine: each cell takes
// the accept, height and compare steps, with one more compare step per stack
// pop; a row end adds flush steps, one per entry left on the stack and a
// last one that finds it empty. Every entry is pushed and popped once, and
// the sequencer takes one step per cycle. With the output register free, the
// last product is registered, folded into the running best, then loaded out.
//
// Reset clears the column heights (valid bits), the stack, the column
// position and the running best; there is no clearing pass. A result held by
// a stalled receiver stays on out_ch; the next matrix is accepted meanwhile
// and only its own result waits for the output register to free up.
`default_nettype none
module maximal_rectangle_binary_matrix_top #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mrbm_in_if.sink                       in_ch,
  mrbm_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mrbm_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [mrbm_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [mrbm_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import mrbm_pkg::*;

  logic [NCOLS_W-1:0] num_cols_r;
  logic [CFG_AW-3:0]  cfg_idx;
  logic               cfg_wr;
  mrbm_cmd_t          cmd;
  mrbm_sts_t          sts;

  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_idx == REG_NUM_COLS) ? CFG_DW'(num_cols_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= NCOLS_RESET;
    end else if (cfg_wr && (cfg_idx == REG_NUM_COLS)) begin
      num_cols_r <= cfg_pwdata[NCOLS_W-1:0];
    end
  end

  mrbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mrbm_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_cell   (in_ch.cell_bit),
    .in_last   (in_ch.last_cell),
    .num_cols  (num_cols_r),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_area  (out_ch.rect_area)
  );

endmodule
`default_nettype wire

FILE: hdl/mrbm_chk.sv
// Port-level checker for the maximal-rectangle block and its bind to the
// top level. Depends on mrbm_pkg and maximal_rectangle_binary_matrix_top.
`default_nettype none
module mrbm_chk #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mrbm_pkg::AREA_W-1:0]   rect_area
);
  import mrbm_pkg::*;

  localparam int FULL = MAX_COLS * MAX_ROWS;
  localparam int BOUND = (FULL > int'(AREA_CAP)) ? int'(AREA_CAP) : FULL;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(rect_area))
    else $error("result changed or dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one cell at a time: the channel closes after a transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a cell is in work");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after a cell transfer");

  a_area_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(rect_area) <= BOUND))
    else $error("area larger than the matrix");

endmodule

bind maximal_rectangle_binary_matrix_top mrbm_chk #(
  .MAX_COLS (MAX_COLS),
  .MAX_ROWS (MAX_ROWS)
) u_mrbm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .rect_area (out_ch.rect_area)
);
`default_nettype wire

FILE: test/mrbm_area_checker.sv
// Checker for the maximal-rectangle block: watches the cell, result and cfg ports,
// predicts rect_area per matrix and compares each result transfer with it.
// Depends on mrbm_pkg and the stream interfaces in hdl/mrbm_if.sv.
`timescale 1ns / 100ps
module mrbm_area_checker #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mrbm_in_if                          in_mon,
  mrbm_out_if                         out_mon,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic                        cfg_pready,
  input  logic [mrbm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [mrbm_pkg::CFG_DW-1:0] cfg_pwdata,
  output int                          fail_count,
  output int                          pending
);
  import mrbm_pkg::*;

  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int SW = $clog2(MAX_COLS);
  localparam int DW = $clog2(MAX_COLS + 1);

  logic [NCOLS_W-1:0] ncols;
  logic [HW-1:0]      col_hgt   [MAX_COLS];
  logic [HW-1:0]      stk_hgt   [MAX_COLS];
  logic [SW-1:0]      stk_start [MAX_COLS];
  logic [DW-1:0]      stk_depth;
  logic [SW-1:0]      col_pos;
  logic [AREA_W-1:0]  best_area;
  logic [AREA_W-1:0]  expected_areas[$];
  logic [AREA_W-1:0]  want;

  initial fail_count = 0;

  task automatic clear_matrix();
    for (int i = 0; i < MAX_COLS; i++) begin
      col_hgt[i] = '0;
    end
    stk_depth = '0;
    col_pos   = '0;
    best_area = '0;
  endtask

  task automatic consider_rect(input int h, input int w);
    int prod;
    prod = h * w;
    if (prod > int'(AREA_CAP)) prod = int'(AREA_CAP);
    if (prod > int'(best_area)) best_area = AREA_W'(prod);
  endtask

  // one cell: height update, stack pops/push, row flush, result on last
  task automatic absorb_cell(input logic cbit, input logic lastc);
    int n, col, h, start;
    n = int'(ncols);
    if (n == 0) n = 1;
    if (n > MAX_COLS) n = MAX_COLS;
    col = int'(col_pos);
    h = int'(col_hgt[col]);
    if (cbit) begin
      if (h < MAX_ROWS) h++;
    end else begin
      h = 0;
    end
    col_hgt[col] = HW'(h);
    start = col;
    while (stk_depth > 0 && int'(stk_hgt[stk_depth-1]) >= h) begin
      stk_depth = stk_depth - 1'b1;
      consider_rect(int'(stk_hgt[stk_depth]), col - int'(stk_start[stk_depth]));
      start = int'(stk_start[stk_depth]);
    end
    if (stk_depth < MAX_COLS) begin
      stk_hgt[stk_depth]   = HW'(h);
      stk_start[stk_depth] = SW'(start);
      stk_depth = stk_depth + 1'b1;
    end
    if (col + 1 >= n || lastc) begin
      while (stk_depth > 0) begin
        stk_depth = stk_depth - 1'b1;
        consider_rect(int'(stk_hgt[stk_depth]), col + 1 - int'(stk_start[stk_depth]));
      end
      col_pos = '0;
    end else begin
      col_pos = SW'(col + 1);
    end
    if (lastc) begin
      expected_areas = {expected_areas, best_area};
      clear_matrix();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ncols = NCOLS_RESET;
      clear_matrix();
      expected_areas.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_areas.size() == 0) begin
          $error("rect_area: no result expected, actual %0d", out_mon.rect_area);
          fail_count++;
        end else begin
          want = expected_areas.pop_front();
          if (out_mon.rect_area !== want) begin
            $error("rect_area mismatch: expected %0d, actual %0d", want,
                   out_mon.rect_area);
            fail_count++;
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_AW-1:2] == REG_NUM_COLS) begin
        ncols = cfg_pwdata[NCOLS_W-1:0];
      end
      if (in_mon.valid && in_mon.ready) begin
        absorb_cell(in_mon.cell_bit, in_mon.last_cell);
      end
    end
    pending <= expected_areas.size();
  end

endmodule

FILE: test/tb_top.sv
// Top of the maximal-rectangle testbench: clock, reset, cell and cfg stimulus,
// result-side stalls and the verdict. Depends on mrbm_pkg, hdl/mrbm_if.sv,
// the block's top and mrbm_area_checker.
`timescale 1ns / 100ps
module tb_top;
  import mrbm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 300;  // longest row flush plus output delay, with margin
  localparam int HOLD_LEN    = 600;
  localparam int PHASE_CELLS = 90;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holds_requested = 0;
  int cells_sent = 0;

  mrbm_in_if  in_ch();
  mrbm_out_if out_ch();

  maximal_rectangle_binary_matrix_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  mrbm_area_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stalls, plus long hold-offs on request
  initial begin
    int holds_served;
    holds_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_requested) begin
        holds_served++;
        for (int i = 0; i < HOLD_LEN; i++) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
      default: begin send_idle_pct = 16; recv_stall_pct = 16; end
    endcase
  endtask

  task automatic send_cell(input logic cbit, input logic lastc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cell_bit  <= cbit;
    in_ch.last_cell <= lastc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    cells_sent++;
  endtask

  // drop valid, drain all results, then let the engine finish its flush
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_num_cols(input logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_NUM_COLS, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // row-major matrix; sometimes the last flag lands mid-matrix
  task automatic send_matrix(input int rows, input int cols, input int one_pct,
                             input bit allow_cut);
    int total, cut;
    total = rows * cols;
    cut = total - 1;
    if (allow_cut && $urandom_range(4) == 0) cut = $urandom_range(total - 1);
    for (int k = 0; k <= cut; k++) begin
      send_cell($urandom_range(99) < one_pct, k == cut);
    end
  endtask

  initial begin
    int ncols_set[8];
    int eff, rows, pct;
    ncols_set = '{4, 1, 7, 64, 0, 127, 2, 16};
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.cell_bit  <= 1'b0;
    in_ch.last_cell <= 1'b0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset column count, single cells, small matrices
    set_idling(0);
    send_cell(1'b1, 1'b1);
    send_cell(1'b0, 1'b1);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b1);
    settle();
    // zero columns acts as one column
    write_num_cols(0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b1);
    settle();
    write_num_cols(3);
    send_cell(1'b1, 1'b0); send_cell(1'b1, 1'b0); send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b0); send_cell(1'b1, 1'b0); send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b0); send_cell(1'b1, 1'b0); send_cell(1'b1, 1'b1);
    settle();
    // shrink the row while the position is already past the new end
    write_num_cols(5);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    settle();
    write_num_cols(2);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b1);
    settle();
    // oversized count clamps to the full width
    write_num_cols(127);
    send_cell(1'b1, 1'b1);
    settle();

    // random phases over column counts and idling modes
    for (int p = 0; p < 8; p++) begin
      write_num_cols((p == 6) ? $urandom_range(1, 127) : ncols_set[p]);
      eff = (p == 6) ? -1 : ncols_set[p];
      set_idling(p % 4);
      cells_sent = 0;
      if (eff == 1) begin
        // tall all-ones column: heights saturate
        send_matrix(70, 1, 100, 1'b0);
      end
      while (cells_sent < PHASE_CELLS) begin
        if (eff < 0) eff = int'(chk.ncols);
        if (eff == 0) eff = 1;
        if (eff > 64) eff = 64;
        rows = (eff >= 32) ? $urandom_range(1, 2) : $urandom_range(1, 10);
        case ($urandom_range(3))
          0: pct = 30;
          1: pct = 70;
          2: pct = 90;
          default: pct = 100;
        endcase
        send_matrix(rows, eff, pct, 1'b1);
      end
      settle();
    end

    // back-pressure: long result hold-off while small matrices keep coming
    write_num_cols(2);
    set_idling(0);
    holds_requested++;
    for (int m = 0; m < 40; m++) begin
      send_matrix(1, 2, 70, 1'b0);
    end
    settle();

    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
